// ===== sv/swm_pkg.sv =====
// ----------------------------------------------------------------------------
// swm_pkg
// Shared constants and controller/datapath interface types for the
// sliding-window median filter.
// ----------------------------------------------------------------------------
`default_nettype none

package swm_pkg;

    localparam int SAMPLE_W = 32;
    localparam int MEDIAN_W = 33;
    localparam int WSIZE_W  = 7;

    localparam logic [WSIZE_W-1:0] WSIZE_RESET = 7'd5;

    // index register update
    typedef enum logic [2:0] {
        IDX_HOLD,
        IDX_ZERO,
        IDX_FILL,
        IDX_FILL_M1,
        IDX_INC,
        IDX_DEC
    } swm_idx_op_t;

    // sorted store read address select
    typedef enum logic [2:0] {
        RD_IDX,
        RD_IDX_P1,
        RD_IDX_M1,
        RD_MED_LO,
        RD_MED_HI
    } swm_rd_sel_t;

    // sorted store write data select
    typedef enum logic {
        WR_RDATA,
        WR_SAMPLE
    } swm_wr_src_t;

    typedef struct packed {
        logic        load;
        logic        cfg_wr;
        logic        ring_rd;
        logic        full_cap;
        swm_idx_op_t idx_op;
        logic        fill_dec;
        logic        s_rd;
        swm_rd_sel_t rd_sel;
        logic        s_wr;
        swm_wr_src_t wr_src;
        logic        finish;
        logic        med_cap;
        logic        out_load;
    } swm_cmd_t;

    typedef struct packed {
        logic full;
        logic match;
        logic shift_done;
        logic idx_zero;
        logic greater;
        logic produce;
    } swm_status_t;

endpackage

`default_nettype wire

// ===== sv/swm_datapath.sv =====
// ----------------------------------------------------------------------------
// swm_datapath
// Window storage (sorted store and arrival ring), fill/head counters, index
// register and median adder of the sliding-window median filter.
// ----------------------------------------------------------------------------
`default_nettype none

module swm_datapath #(
    parameter int WINDOW_MAX = 64
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  swm_pkg::swm_cmd_t                     cmd,
    output swm_pkg::swm_status_t                  status,
    input  logic signed [swm_pkg::SAMPLE_W-1:0]   sample,
    input  logic                                  restart,
    input  logic        [swm_pkg::WSIZE_W-1:0]    window_size,
    output logic signed [swm_pkg::MEDIAN_W-1:0]   median_twice
);
    import swm_pkg::*;

    localparam int IW = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
    localparam int CW = $clog2(WINDOW_MAX + 1);

    logic [SAMPLE_W-1:0] sorted_mem [WINDOW_MAX];
    logic [SAMPLE_W-1:0] ring_mem   [WINDOW_MAX];

    logic [WSIZE_W-1:0]         ws_reg;
    logic [CW-1:0]              fill_reg;
    logic [IW-1:0]              head_reg;
    logic [CW-1:0]              idx_reg;
    logic                       full_reg;
    logic signed [SAMPLE_W-1:0] samp_reg;
    logic signed [SAMPLE_W-1:0] s_rdata_reg;
    logic signed [SAMPLE_W-1:0] ring_rdata_reg;
    logic signed [SAMPLE_W-1:0] med_a_reg;
    logic signed [MEDIAN_W-1:0] out_reg;

    logic [CW-1:0]       size;
    logic [CW-1:0]       head_ext;
    logic [CW-1:0]       head_inc;
    logic [IW-1:0]       head_wrap;
    logic [IW-1:0]       med_hi;
    logic [IW-1:0]       med_lo;
    logic [IW-1:0]       s_raddr;
    logic [IW-1:0]       ring_waddr;
    logic [SAMPLE_W-1:0] s_wdata;
    logic                empty_now;

    // effective window length: zero acts as one, oversize clamps
    always_comb
    begin
        if (ws_reg == '0)
            size = CW'(1);
        else if (32'(ws_reg) > 32'(WINDOW_MAX))
            size = CW'(WINDOW_MAX);
        else
            size = CW'(ws_reg);
    end

    assign head_ext  = CW'(head_reg);
    assign head_inc  = head_ext + CW'(1);
    assign head_wrap = (head_inc >= size) ? '0 : IW'(head_inc);
    assign med_hi    = IW'(size >> 1);
    assign med_lo    = size[0] ? med_hi : med_hi - IW'(1);
    assign empty_now = restart || (fill_reg > size) || (head_ext >= size);

    always_comb
    begin
        case (cmd.rd_sel)
            RD_IDX:    s_raddr = idx_reg[IW-1:0];
            RD_IDX_P1: s_raddr = IW'(idx_reg + CW'(1));
            RD_IDX_M1: s_raddr = IW'(idx_reg - CW'(1));
            RD_MED_LO: s_raddr = med_lo;
            RD_MED_HI: s_raddr = med_hi;
            default:   s_raddr = idx_reg[IW-1:0];
        endcase
    end

    assign s_wdata    = (cmd.wr_src == WR_SAMPLE) ? samp_reg : s_rdata_reg;
    assign ring_waddr = full_reg ? head_reg : fill_reg[IW-1:0];

    assign status.full       = (fill_reg == size);
    assign status.match      = (s_rdata_reg == ring_rdata_reg) ||
                               (idx_reg == fill_reg - CW'(1));
    assign status.shift_done = ((idx_reg + CW'(1)) >= fill_reg);
    assign status.idx_zero   = (idx_reg == '0);
    assign status.greater    = (s_rdata_reg > samp_reg);
    assign status.produce    = ((fill_reg + CW'(1)) == size);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ws_reg   <= WSIZE_RESET;
            fill_reg <= '0;
            head_reg <= '0;
            idx_reg  <= '0;
            full_reg <= 1'b0;
        end
        else
        begin
            if (cmd.cfg_wr)
            begin
                ws_reg   <= window_size;
                fill_reg <= '0;
                head_reg <= '0;
            end
            else if (cmd.load && empty_now)
            begin
                fill_reg <= '0;
                head_reg <= '0;
            end
            else if (cmd.fill_dec)
                fill_reg <= fill_reg - CW'(1);
            else if (cmd.finish)
            begin
                fill_reg <= fill_reg + CW'(1);
                head_reg <= full_reg ? head_wrap : '0;
            end

            if (cmd.full_cap)
                full_reg <= status.full;

            case (cmd.idx_op)
                IDX_HOLD:    idx_reg <= idx_reg;
                IDX_ZERO:    idx_reg <= '0;
                IDX_FILL:    idx_reg <= fill_reg;
                IDX_FILL_M1: idx_reg <= fill_reg - CW'(1);
                IDX_INC:     idx_reg <= idx_reg + CW'(1);
                IDX_DEC:     idx_reg <= idx_reg - CW'(1);
                default:     idx_reg <= idx_reg;
            endcase
        end
    end

    // storage and payload
    always_ff @(posedge clk)
    begin
        if (cmd.s_wr)
            sorted_mem[idx_reg[IW-1:0]] <= s_wdata;
        if (cmd.s_rd)
            s_rdata_reg <= sorted_mem[s_raddr];
        if (cmd.finish)
            ring_mem[ring_waddr] <= samp_reg;
        if (cmd.ring_rd)
            ring_rdata_reg <= ring_mem[head_reg];
        if (cmd.load)
            samp_reg <= sample;
        if (cmd.med_cap)
            med_a_reg <= s_rdata_reg;
        // odd windows read the middle entry twice, so the sum is 2 * median
        if (cmd.out_load)
            out_reg <= MEDIAN_W'(med_a_reg) + MEDIAN_W'(s_rdata_reg);
    end

    assign median_twice = out_reg;

endmodule

`default_nettype wire

// ===== sv/swm_ctrl.sv =====
// ----------------------------------------------------------------------------
// swm_ctrl
// Sequencer of the sliding-window median filter: drops the oldest sample from
// the sorted store if full, inserts the new one, reads the median once full.
// ----------------------------------------------------------------------------
`default_nettype none

module swm_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    output logic                 out_valid,
    input  logic                 out_stall,
    input  swm_pkg::swm_status_t status,
    output swm_pkg::swm_cmd_t    cmd
);
    import swm_pkg::*;

    typedef enum logic [11:0] {
        S_IDLE    = 12'b0000_0000_0001,
        S_EVAL    = 12'b0000_0000_0010,
        S_RM_RD   = 12'b0000_0000_0100,
        S_RM_CHK  = 12'b0000_0000_1000,
        S_SH_RD   = 12'b0000_0001_0000,
        S_SH_WR   = 12'b0000_0010_0000,
        S_IN_RD   = 12'b0000_0100_0000,
        S_IN_CHK  = 12'b0000_1000_0000,
        S_FIN     = 12'b0001_0000_0000,
        S_MED_RD0 = 12'b0010_0000_0000,
        S_MED_RD1 = 12'b0100_0000_0000,
        S_MED_SUM = 12'b1000_0000_0000
    } swm_state_t;

    swm_state_t state_reg;
    swm_state_t state_next;
    logic       out_valid_reg;
    logic       out_valid_next;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (cfg_valid)
                    cmd.cfg_wr = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_EVAL;
                end
            end
            S_EVAL:
            begin
                cmd.full_cap = 1'b1;
                if (status.full)
                begin
                    cmd.ring_rd = 1'b1;
                    cmd.idx_op  = IDX_ZERO;
                    state_next  = S_RM_RD;
                end
                else
                begin
                    cmd.idx_op = IDX_FILL;
                    state_next = S_IN_RD;
                end
            end
            S_RM_RD:
            begin
                cmd.s_rd   = 1'b1;
                cmd.rd_sel = RD_IDX;
                state_next = S_RM_CHK;
            end
            S_RM_CHK:
            begin
                if (status.match)
                    state_next = S_SH_RD;
                else
                begin
                    cmd.idx_op = IDX_INC;
                    state_next = S_RM_RD;
                end
            end
            S_SH_RD:
            begin
                // close the gap left by the oldest sample, then insert
                if (status.shift_done)
                begin
                    cmd.fill_dec = 1'b1;
                    cmd.idx_op   = IDX_FILL_M1;
                    state_next   = S_IN_RD;
                end
                else
                begin
                    cmd.s_rd   = 1'b1;
                    cmd.rd_sel = RD_IDX_P1;
                    state_next = S_SH_WR;
                end
            end
            S_SH_WR:
            begin
                cmd.s_wr   = 1'b1;
                cmd.wr_src = WR_RDATA;
                cmd.idx_op = IDX_INC;
                state_next = S_SH_RD;
            end
            S_IN_RD:
            begin
                if (status.idx_zero)
                begin
                    cmd.s_wr   = 1'b1;
                    cmd.wr_src = WR_SAMPLE;
                    state_next = S_FIN;
                end
                else
                begin
                    cmd.s_rd   = 1'b1;
                    cmd.rd_sel = RD_IDX_M1;
                    state_next = S_IN_CHK;
                end
            end
            S_IN_CHK:
            begin
                // move larger entries up one slot until the place is found
                if (status.greater)
                begin
                    cmd.s_wr   = 1'b1;
                    cmd.wr_src = WR_RDATA;
                    cmd.idx_op = IDX_DEC;
                    state_next = S_IN_RD;
                end
                else
                begin
                    cmd.s_wr   = 1'b1;
                    cmd.wr_src = WR_SAMPLE;
                    state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                cmd.finish = 1'b1;
                state_next = status.produce ? S_MED_RD0 : S_IDLE;
            end
            S_MED_RD0:
            begin
                cmd.s_rd   = 1'b1;
                cmd.rd_sel = RD_MED_LO;
                state_next = S_MED_RD1;
            end
            S_MED_RD1:
            begin
                cmd.s_rd    = 1'b1;
                cmd.rd_sel  = RD_MED_HI;
                cmd.med_cap = 1'b1;
                state_next  = S_MED_SUM;
            end
            S_MED_SUM:
            begin
                // hold until the output register is free
                if (!out_valid_reg || !out_stall)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        if (cmd.out_load)
            out_valid_next = 1'b1;
        else if (!out_stall)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_stall  = (state_reg != S_IDLE);
    assign cfg_ready = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

endmodule

`default_nettype wire

// ===== sv/sliding_window_median_top.sv =====
// ----------------------------------------------------------------------------
// sliding_window_median_top
// Sliding-window median filter over signed 32-bit samples.
//
// Input beats (sample, restart) arrive on in_valid/in_stall; restart empties
// the window before its sample enters. Result beats carry median_twice, the
// window median times two, on out_valid/out_stall, one per sample once the
// window holds its effective size in samples. window_size is written on
// cfg_valid/cfg_ready while the block is idle; a write empties the window.
// One sample is processed at a time. The sorted store has one read and one
// write port, so removing the oldest sample and inserting the new one walk
// it one entry at a time; the median is then read at the two middle entries
// and summed. A result waits in the output register while out_stall is high
// and the next sample is already accepted; it stalls only at the point where
// its own result would need that register.
// Reset empties the window and sets window_size to 5; stored samples are
// not cleared, so no clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none

module sliding_window_median_top #(
    parameter int WINDOW_MAX = 64
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic signed [swm_pkg::SAMPLE_W-1:0] sample,
    input  logic                                restart,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic signed [swm_pkg::MEDIAN_W-1:0] median_twice,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic        [swm_pkg::WSIZE_W-1:0]  window_size
);
    import swm_pkg::*;

    swm_cmd_t    cmd;
    swm_status_t status;

    swm_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .cmd       (cmd)
    );

    swm_datapath #(
        .WINDOW_MAX (WINDOW_MAX)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .sample       (sample),
        .restart      (restart),
        .window_size  (window_size),
        .median_twice (median_twice)
    );

endmodule

`default_nettype wire

// ===== sv/swm_checker.sv =====
// ----------------------------------------------------------------------------
// swm_checker
// Port-level checks of the sliding-window median filter, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none

module swm_checker (
    input wire logic                                clk,
    input wire logic                                rst_n,
    input wire logic                                in_valid,
    input wire logic                                in_stall,
    input wire logic                                out_valid,
    input wire logic                                out_stall,
    input wire logic signed [swm_pkg::MEDIAN_W-1:0] median_twice,
    input wire logic                                cfg_valid,
    input wire logic                                cfg_ready
);

    // a stalled result beat stays offered
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result beat dropped while stalled");

    // a stalled result beat keeps its value
    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(median_twice))
        else $error("result changed while stalled");

    // one sample at a time: busy right after an accepted beat
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("input accepted back to back");

    // configuration and samples are taken in the same idle window only
    a_cfg_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_ready == !in_stall)
        else $error("config ready out of step with input");

    // a config write alone does not start any work
    a_cfg_no_work: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid && cfg_ready && !in_valid |=> cfg_ready)
        else $error("config write left the block busy");

endmodule

bind sliding_window_median_top swm_checker u_swm_checker (.*);

`default_nettype wire
